// File: hdl/tccs_pkg.sv
// Shared constants and helpers for the text console cursor/scroll core.
package tccs_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COPY_N   = COLUMNS * (ROWS - 1);

  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);

  localparam int KIND_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 11;
  localparam int POS_W    = 11;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 24;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef logic [CNT_W-1:0] lin_t;

  // Linear position row*COLUMNS+col; constant multiply, narrow operands.
  function automatic lin_t cursor_lin(input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    lin_t prod;
    prod = CNT_W'(row) * CNT_W'(COLUMNS);
    return prod + CNT_W'(col);
  endfunction

endpackage

// File: hdl/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tccs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/text_console_cursor_scroll_core.sv
// Text console engine: cursor tracking, character store, scroll and clear.
// Every item yields one result beat; a clear blanks the whole store and a write
// that scrolls copies it up one row and blanks the last row; one item at a time,
// set by the single RAM port pair that every sweep walks one cell per cycle.
// Reset: synchronous active-low; afterwards a clearing pass over all CELLS (2000)
// cells fills the store with spaces while in_tready stays low.
module text_console_cursor_scroll_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tccs_pkg::IN_DW-1:0]  in_tdata,  // kind[1:0], char_code[9:2], cell_index[20:10]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [tccs_pkg::OUT_DW-1:0] out_tdata  // cursor_pos[10:0], read_char[18:11]
);
  import tccs_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDATA  = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              pend_r, pend_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CHAR_W-1:0] rd_r, rd_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DW-1:0] out_tdata_r, out_tdata_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic [KIND_W-1:0] in_kind;
  logic [CHAR_W-1:0] in_char;
  logic [CELL_W-1:0] in_cell;
  logic              in_acc;
  logic              is_cr, is_lf, wrap, newline;
  lin_t              lin;
  logic [CNT_W+POS_W-1:0]  lin_ext;
  logic [ADDR_W+CELL_W-1:0] cell_ext;
  logic              cell_ok;
  lin_t              k_rd, k_wr;

  assign in_kind = in_tdata[1:0];
  assign in_char = in_tdata[9:2];
  assign in_cell = in_tdata[20:10];
  assign in_acc  = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign lin      = cursor_lin(row_r, col_r);
  assign lin_ext  = {{POS_W{1'b0}}, lin};
  assign cell_ext = {{ADDR_W{1'b0}}, in_cell};
  assign cell_ok  = (32'(in_cell) < 32'(CELLS));
  assign k_rd     = k_r + CNT_W'(COLUMNS);
  assign k_wr     = k_r - CNT_W'(1);

  assign is_cr   = (in_char == CH_CR);
  assign is_lf   = (in_char == CH_LF);
  assign wrap    = !is_cr && !is_lf && (col_r == COL_W'(COLUMNS - 1));
  assign newline = is_lf || wrap;

  tccs_ram #(
    .DATA_W (CHAR_W),
    .DEPTH  (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    rd_ok_nxt      = rd_ok_r;
    rd_nxt         = rd_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = lin[ADDR_W-1:0];
    ram_wdata      = in_char;
    ram_raddr      = cell_ext[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pend_nxt  = 1'b1;
          rd_nxt    = '0;
          state_nxt = ST_DONE;
          case (in_kind)
            KIND_WRITE: begin
              ram_we  = !is_cr && !is_lf;
              col_nxt = (is_cr || newline) ? '0 : col_r + COL_W'(1);
              if (newline) begin
                if (row_r == ROW_W'(ROWS - 1)) begin
                  k_nxt     = '0;
                  state_nxt = ST_SCROLL;
                end else begin
                  row_nxt = row_r + ROW_W'(1);
                end
              end
            end
            KIND_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              k_nxt     = '0;
              state_nxt = ST_FILL;
            end
            KIND_READ: begin
              rd_ok_nxt = cell_ok;
              state_nxt = ST_RDATA;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_RDATA: begin
        rd_nxt    = rd_ok_r ? ram_rdata : '0;
        state_nxt = ST_DONE;
      end

      // Copy pipeline: read cell k+COLUMNS, write the previous beat to k-1.
      ST_SCROLL: begin
        ram_raddr = k_rd[ADDR_W-1:0];
        ram_waddr = k_wr[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_we    = (k_r != '0);
        if (k_r == CNT_W'(COPY_N)) begin
          state_nxt = ST_FILL;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[ADDR_W-1:0];
        ram_wdata = CH_SPACE;
        if (k_r == CNT_W'(CELLS - 1)) begin
          state_nxt = pend_r ? ST_DONE : ST_IDLE;
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DW'({rd_r, lin_ext[POS_W-1:0]});
          pend_nxt       = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      col_r        <= '0;
      row_r        <= '0;
      k_r          <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      k_r          <= k_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r     <= rd_ok_nxt;
    rd_r        <= rd_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < 32'(COLUMNS)) && (32'(row_r) < 32'(ROWS)))
    else $error("cursor out of screen");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item taken while busy");

  a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_IDLE) |-> (in_acc && in_kind == KIND_WRITE))
    else $error("store written while idle without a write beat");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL || state_r == ST_SCROLL) |-> (32'(k_r) < 32'(CELLS)))
    else $error("sweep counter past store");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> pend_r)
    else $error("result stage without pending item");

endmodule
